@@ sv/reverse_word_order_top_assert.svh @@
// assertion macros for the reverse word order block
// depends on nothing; the including module provides clk and rst_n
`ifndef REVERSE_WORD_ORDER_TOP_ASSERT_SVH
`define REVERSE_WORD_ORDER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define RWO_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define RWO_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define RWO_ASSERT_IMP(lbl, pre, post, msg)
`define RWO_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

@@ sv/rwo_pkg.sv @@
// shared types and constants of the reverse word order block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rwo_pkg;
    localparam int MAX_LEN_DEF = 64;
    localparam int CHR_W       = 8;
    localparam logic [CHR_W-1:0] SPACE_CHAR = 8'h20;

    // one result transfer
    typedef struct packed {
        logic [CHR_W-1:0] chr;
        logic             last;
        logic             empty;
        logic             trunc;
    } item_t;

    // sequencer status
    typedef struct packed {
        logic busy;
        logic loading;
    } seq_status_t;
endpackage
`default_nettype wire

@@ sv/rwo_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module rwo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

@@ sv/rwo_seq.sv @@
// sequencer: loads the line buffer, scans it backwards and emits words
// depends on rwo_pkg; drives the ports of one rwo_ram
`timescale 1ns / 1ps
`default_nettype none
module rwo_seq
    import rwo_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [CHR_W-1:0]           in_chr,
    input  wire logic                       in_last,
    output logic                            in_ready,
    output logic                            ram_we,
    output logic [$clog2(MAX_LEN)-1:0]      ram_waddr,
    output logic [CHR_W-1:0]                ram_wdata,
    output logic                            ram_re,
    output logic [$clog2(MAX_LEN)-1:0]      ram_raddr,
    input  wire logic [CHR_W-1:0]           ram_rdata,
    output logic                            push_valid,
    input  wire logic                       push_ready,
    output item_t                           push_item,
    output seq_status_t                     status
);
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

    typedef enum logic [8:0] {
        S_LOAD     = 9'b000000001,
        S_SKIP     = 9'b000000010,
        S_SKIP_CHK = 9'b000000100,
        S_FIND     = 9'b000001000,
        S_FIND_CHK = 9'b000010000,
        S_EMIT_SEP = 9'b000100000,
        S_EMIT_RD  = 9'b001000000,
        S_EMIT_WR  = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t         state_reg, state_next;
    logic  [CW-1:0] fill_reg, fill_next;
    logic  [CW-1:0] ptr_reg, ptr_next;
    logic  [CW-1:0] end_reg, end_next;
    logic  [CW-1:0] emit_reg, emit_next;
    logic           ovf_reg, ovf_next;
    logic           first_reg, first_next;
    logic           pend_valid_reg, pend_valid_next;
    item_t          pend_reg, pend_next;
    logic           can_take;
    logic  [CW-1:0] ptr_dec;

    assign ptr_dec  = ptr_reg - ONE;
    // pending slot frees when empty or when its item is pushed this cycle
    assign can_take = !pend_valid_reg || push_ready;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        emit_next       = emit_reg;
        ovf_next        = ovf_reg;
        first_next      = first_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        in_ready        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = fill_reg[AW-1:0];
        ram_wdata       = in_chr;
        ram_re          = 1'b0;
        ram_raddr       = ptr_dec[AW-1:0];
        push_valid      = 1'b0;
        push_item       = pend_reg;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (fill_reg < FULL)
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + ONE;
                        ptr_next  = fill_reg + ONE;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        ptr_next = fill_reg;
                    end
                    if (in_last)
                    begin
                        state_next = S_SKIP;
                    end
                end
            end
            S_SKIP:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_SKIP_CHK;
                end
            end
            S_SKIP_CHK:
            begin
                ptr_next = ptr_dec;
                if (ram_rdata == SPACE_CHAR)
                begin
                    state_next = S_SKIP;
                end
                else
                begin
                    end_next   = ptr_reg;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                if (ptr_reg == '0)
                begin
                    emit_next  = ptr_reg;
                    state_next = S_EMIT_SEP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_FIND_CHK;
                end
            end
            S_FIND_CHK:
            begin
                if (ram_rdata == SPACE_CHAR)
                begin
                    emit_next  = ptr_reg;
                    state_next = S_EMIT_SEP;
                end
                else
                begin
                    ptr_next   = ptr_dec;
                    state_next = S_FIND;
                end
            end
            S_EMIT_SEP:
            begin
                push_valid = pend_valid_reg;
                if (first_reg)
                begin
                    state_next = S_EMIT_RD;
                end
                else if (can_take)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = '{chr: SPACE_CHAR, last: 1'b0, empty: 1'b0,
                                        trunc: ovf_reg};
                    state_next      = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                if (emit_reg == end_reg)
                begin
                    first_next = 1'b0;
                    state_next = S_SKIP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = emit_reg[AW-1:0];
                    state_next = S_EMIT_WR;
                end
            end
            S_EMIT_WR:
            begin
                push_valid = pend_valid_reg;
                if (can_take)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = '{chr: ram_rdata, last: 1'b0, empty: 1'b0,
                                        trunc: ovf_reg};
                    emit_next       = emit_reg + ONE;
                    state_next      = S_EMIT_RD;
                end
            end
            S_DONE:
            begin
                push_valid = 1'b1;
                if (pend_valid_reg)
                begin
                    push_item = '{chr: pend_reg.chr, last: 1'b1, empty: 1'b0,
                                  trunc: ovf_reg};
                end
                else
                begin
                    push_item = '{chr: '0, last: 1'b1, empty: 1'b1, trunc: ovf_reg};
                end
                if (push_ready)
                begin
                    fill_next       = '0;
                    ovf_next        = 1'b0;
                    first_next      = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            first_reg      <= 1'b1;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            ovf_reg        <= ovf_next;
            first_reg      <= first_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        end_reg  <= end_next;
        emit_reg <= emit_next;
        pend_reg <= pend_next;
    end

    assign status.busy    = (state_reg != S_LOAD);
    assign status.loading = (state_reg == S_LOAD);
endmodule
`default_nettype wire

@@ sv/reverse_word_order_top.sv @@
// reverse word order: line buffer ram, scan sequencer and output register
// depends on rwo_pkg, rwo_ram, rwo_seq and reverse_word_order_top_assert.svh
// loading takes one byte transfer a cycle; from the last byte on no byte is taken until the
// final result is handed off; each byte is scanned once (a space before a word twice)
// and each word is read out again byte by byte; reset: async, clears all control
`timescale 1ns / 1ps
`default_nettype none
`include "reverse_word_order_top_assert.svh"
module reverse_word_order_top
    import rwo_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [CHR_W-1:0] s_axis_tdata,   // in_byte
    input  wire logic             s_axis_tlast,   // in_last
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [CHR_W-1:0] m_axis_tdata,   // out_byte
    output logic                  m_axis_tlast,   // out_last
    output logic      [1:0]       m_axis_tuser    // out_empty, truncated
);
    localparam int AW = $clog2(MAX_LEN);

    // line buffer port signals
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CHR_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [CHR_W-1:0] ram_rdata;

    // sequencer to output register hand-off
    logic        push_valid;
    logic        push_ready;
    item_t       push_item;
    seq_status_t status;

    // output register
    logic  out_valid_reg, out_valid_next;
    item_t out_item_reg, out_item_next;

    // conditions watched by the checks
    logic final_push;
    logic empty_out;

    // line buffer, written while loading, read during the scan
    rwo_ram #(
        .WIDTH (CHR_W),
        .DEPTH (MAX_LEN)
    ) u_line_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // scan sequencer sharing one read and compare path
    rwo_seq #(
        .MAX_LEN (MAX_LEN)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_chr     (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .status     (status)
    );

    // output stage frees when empty or drained this cycle
    assign push_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (push_ready)
        begin
            out_valid_next = push_valid;
            if (push_valid)
            begin
                out_item_next = push_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_item_reg.chr;
    assign m_axis_tlast    = out_item_reg.last;
    assign m_axis_tuser[0] = out_item_reg.empty;
    assign m_axis_tuser[1] = out_item_reg.trunc;

    assign final_push = push_valid && push_ready && push_item.last;
    assign empty_out  = m_axis_tvalid && m_axis_tuser[0];

    // the block takes no byte while it scans
    `RWO_ASSERT_IMP(a_no_load_in_scan, status.busy, !s_axis_tready && !ram_we, "byte in scan")
    // the final result transfer of a string hands control back to loading
    `RWO_ASSERT_NXT(a_back_to_load, final_push, status.loading, "no return to loading")
    // an empty result is always the single, final and zero one
    `RWO_ASSERT_IMP(a_empty_form, empty_out, m_axis_tlast && (m_axis_tdata == '0), "bad empty")
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// self-checking bench for reverse_word_order_top: streams byte strings in and checks the
// reordered words, the empty flag and the truncation flag coming out
// depends on rwo_pkg and reverse_word_order_top
`timescale 1ns / 1ps
module tb_top;
    import rwo_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 30;
    // settle time scales with the line buffer depth
    localparam int SETTLE_CYCLES = 5 * MAX_LEN_DEF + 8;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [CHR_W-1:0] s_axis_tdata  = '0;
    logic             s_axis_tlast  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [CHR_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;
    logic [1:0]       m_axis_tuser;

    // idling controls, changed between strings by the tests
    bit gaps_on   = 1'b0;
    bit stalls_on = 1'b0;
    bit hold_ask  = 1'b0;

    // run statistics
    int cycle_count     = 0;
    int mismatch_count  = 0;
    int chars_sent      = 0;
    int lines_sent      = 0;
    int chars_checked   = 0;
    int truncated_lines = 0;
    int holds_done      = 0;

    // expected model of the block: its own line buffer and the queue of awaited result bytes
    logic [CHR_W-1:0] line_mem [MAX_LEN_DEF];
    int               fill_level    = 0;
    bit               overflow_mark = 1'b0;
    item_t            awaited_chars [$];

    // string under construction for the sender
    logic [CHR_W-1:0] line_q [$];

    always #CLK_HALF clk = ~clk;

    reverse_word_order_top #(
        .MAX_LEN(MAX_LEN_DEF)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // in_byte
        .s_axis_tlast (s_axis_tlast),   // in_last
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // out_byte
        .m_axis_tlast (m_axis_tlast),   // out_last
        .m_axis_tuser (m_axis_tuser)    // out_empty, truncated
    );

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("reverse_word_order_top test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[cycle %0d] mismatch: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------------
    // expected model
    // ---------------------------------------------------------------------

    function automatic item_t make_char(input logic [CHR_W-1:0] c);
        item_t r;
        r.chr   = c;
        r.last  = 1'b0;
        r.empty = 1'b0;
        r.trunc = overflow_mark;
        return r;
    endfunction

    // walk the stored line backwards, emit each word forwards, single spaces between words
    function automatic void reorder_line();
        item_t out_q [$];
        item_t r;
        int    pos;
        int    start;
        bit    first_word;
        first_word = 1'b1;
        pos        = fill_level - 1;
        while (pos >= 0)
        begin
            // skip a run of spaces
            while (pos >= 0 && line_mem[pos] == SPACE_CHAR)
                pos--;
            if (pos < 0)
                break;
            // find the left end of this word
            start = pos;
            while (start >= 0 && line_mem[start] != SPACE_CHAR)
                start--;
            if (!first_word && out_q.size() < MAX_LEN_DEF)
                out_q = {out_q, make_char(SPACE_CHAR)};
            for (int k = start + 1; k <= pos && out_q.size() < MAX_LEN_DEF; k++)
                out_q = {out_q, make_char(line_mem[k])};
            first_word = 1'b0;
            pos        = start;
        end
        if (out_q.size() == 0)
        begin
            // no words at all: a single zero byte flagged empty
            r       = make_char('0);
            r.last  = 1'b1;
            r.empty = 1'b1;
            out_q   = {out_q, r};
        end
        else
            out_q[out_q.size() - 1].last = 1'b1;
        awaited_chars = {awaited_chars, out_q};
        if (overflow_mark)
            truncated_lines++;
        fill_level    = 0;
        overflow_mark = 1'b0;
    endfunction

    function automatic void store_char(input logic [CHR_W-1:0] c, input logic is_last);
        if (fill_level < MAX_LEN_DEF)
        begin
            line_mem[fill_level] = c;
            fill_level++;
        end
        else
            overflow_mark = 1'b1;   // dropped, but a dropped last byte still ends the string
        if (is_last)
            reorder_line();
    endfunction

    // every input transfer feeds the model
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            store_char(s_axis_tdata, s_axis_tlast);
    end

    // every output transfer is compared with the oldest awaited byte
    always @(posedge clk)
    begin : result_check
        item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_chars.size() == 0)
                report_mismatch($sformatf("unexpected result byte %02h last %0b user %02b",
                                          m_axis_tdata, m_axis_tlast, m_axis_tuser));
            else
            begin
                want = awaited_chars.pop_front();
                chars_checked++;
                if (m_axis_tdata !== want.chr || m_axis_tlast !== want.last ||
                    m_axis_tuser[0] !== want.empty || m_axis_tuser[1] !== want.trunc)
                    report_mismatch($sformatf(
                        "got byte %02h last %0b empty %0b trunc %0b, want %02h %0b %0b %0b",
                        m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1],
                        want.chr, want.last, want.empty, want.trunc));
            end
        end
    end

    // ---------------------------------------------------------------------
    // receiver: random stall before each transfer, long hold-off on request
    // ---------------------------------------------------------------------
    initial
    begin : receiver
        int wait_n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            wait_n = stalls_on ? $urandom_range(0, 3) : 0;
            if (hold_ask)
            begin
                // long hold-off so the block backs up and stalls its input
                hold_ask = 1'b0;
                wait_n  += HOLD_CYCLES;
                holds_done++;
            end
            if (wait_n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // ---------------------------------------------------------------------
    // sender helpers
    // ---------------------------------------------------------------------

    // one byte transfer, with a random gap in front of it
    task automatic send_char(input logic [CHR_W-1:0] c, input logic is_last);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_char(line_q[i], i == line_q.size() - 1);
        line_q.delete();
        lines_sent++;
    endtask

    // sender goes quiet until every awaited byte has been seen
    task automatic wait_all_out(input int pad);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_chars.size() != 0)
            @(posedge clk);
        repeat (pad) @(posedge clk);
    endtask

    function automatic logic [CHR_W-1:0] pick_char(input bit wild);
        logic [CHR_W-1:0] c;
        if (!wild)
            return 8'h61 + CHR_W'($urandom_range(0, 25));   // lower-case letters
        do
            c = CHR_W'($urandom_range(0, 255));
        while (c == SPACE_CHAR);
        return c;
    endfunction

    task automatic add_word(input int len, input bit wild);
        repeat (len) line_q = {line_q, pick_char(wild)};
    endtask

    task automatic add_spaces(input int n);
        repeat (n) line_q = {line_q, SPACE_CHAR};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q = {line_q, s[i]};
    endtask

    // leading, separating and trailing space runs around a few words
    task automatic add_sentence(input int max_words, input int max_len);
        int n_words;
        n_words = $urandom_range(1, max_words);
        add_spaces($urandom_range(0, 2));
        for (int w = 0; w < n_words; w++)
        begin
            if (w > 0)
                add_spaces($urandom_range(1, 3));
            add_word($urandom_range(1, max_len), $urandom_range(0, 3) == 0);
        end
        add_spaces($urandom_range(0, 2));
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // single-byte string and a plain sentence
    task automatic test_plain_words();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        add_text("a");
        send_line();
        add_text("hi there you");
        send_line();
        wait_all_out(2);
    endtask

    // lone space, all spaces, and space runs at both ends and in between
    task automatic test_space_runs();
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        add_text(" ");
        send_line();
        add_spaces(4);
        send_line();
        add_text("  ab   cd  e  ");
        send_line();
        wait_all_out(2);
    endtask

    // zero and all-ones bytes are word characters; neighbours of the space code too
    task automatic test_char_extremes();
        gaps_on   = 1'b1;
        stalls_on = 1'b0;
        line_q = '{8'h00, SPACE_CHAR, 8'hFF};
        send_line();
        line_q = '{8'h1F, 8'h21, SPACE_CHAR, 8'h7F, 8'h80, SPACE_CHAR, 8'hDF};
        send_line();
        wait_all_out(2);
    endtask

    // full buffer of single-spaced words with the last byte dropped past capacity
    task automatic test_full_line();
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        // words from the first to the final entry: the longest possible result
        add_word(2, 1'b1);
        repeat (MAX_LEN_DEF / 2 - 1)
        begin
            add_spaces(1);
            add_word(1, 1'b1);
        end
        // one byte past capacity, dropped but still ending the string
        add_word(1, 1'b0);
        send_line();
        // truncation mark must be gone for the next string
        add_text("ok go");
        send_line();
        wait_all_out(2);
    endtask

    // receiver holds off while several strings are offered back to back
    task automatic test_receiver_hold();
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        hold_ask  = 1'b1;
        repeat (3)
        begin
            add_sentence(3, 5);
            send_line();
        end
        wait_all_out(2);
    endtask

    // mostly well-formed sentences with random content, plus noise
    task automatic test_random_lines();
        int first_char;
        first_char = chars_sent;
        while (chars_sent - first_char < RANDOM_ITEMS)
        begin
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 19))
                13, 14, 15:
                begin
                    // noise: any byte, about a third of them spaces
                    repeat ($urandom_range(1, 12))
                        line_q = {line_q, ($urandom_range(0, 2) == 0) ? SPACE_CHAR
                                                                      : pick_char(1'b1)};
                end
                16:
                    add_spaces($urandom_range(1, 5));
                17:
                    add_word($urandom_range(1, 8), 1'b1);
                default:
                    add_sentence(5, 7);
            endcase
            send_line();
            if ($urandom_range(0, 5) == 0)
                wait_all_out(2);
        end
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_words();
        test_space_runs();
        test_char_extremes();
        test_full_line();
        test_receiver_hold();
        test_random_lines();

        // drain, then give the block time to show any stray transfer
        wait_all_out(SETTLE_CYCLES);

        $display("run covered %0d strings, %0d bytes in, %0d result bytes checked",
                 lines_sent, chars_sent, chars_checked);
        $display("%0d strings overran the line buffer, %0d long receiver hold-offs, %0d errors",
                 truncated_lines, holds_done, mismatch_count);
        if (mismatch_count == 0 && awaited_chars.size() == 0)
            $display("reverse_word_order_top test passed");
        else
            $display("reverse_word_order_top test failed");
        $finish;
    end

endmodule
